[rtl/fbb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbb_pkg
// Shared constants, codes and types of the page framebuffer blitter.
// ----------------------------------------------------------------------------
package fbb_pkg;

   localparam int COL_LIMIT   = 128;
   localparam int LINE_LIMIT  = 64;
   localparam int LANES       = 8;
   localparam int LANE_W      = $clog2(LANES);
   localparam int STORE_BYTES = (COL_LIMIT * LINE_LIMIT) / 8;
   localparam int LANE_ROWS   = STORE_BYTES / LANES;
   localparam int ROW_W       = $clog2(LANE_ROWS);

   typedef enum logic [1:0] {
      OP_DRAW  = 2'd0,
      OP_AREA  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_CLEAR,
      ST_RD_ISSUE,
      ST_RD_EMIT
   } state_type;

   localparam logic CSR_COLUMNS = 1'b0;
   localparam logic CSR_LINES   = 1'b1;

   // Command to one store lane: a read with an optional bit update in the cycle
   // after the read, and an independent clearing write.
   typedef struct packed {
      logic             rd_en;
      logic [ROW_W-1:0] rd_row;
      logic             modify;
      logic [2:0]       bit_sel;
      logic             bit_val;
      logic             clr_en;
      logic [ROW_W-1:0] clr_row;
   } lane_cmd_type;

endpackage

[rtl/fbb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbb_if
// Request and response channels of the page framebuffer blitter.
// ----------------------------------------------------------------------------
interface fbb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] pos_x;
   logic [7:0] pos_y;
   logic       pixel_on;
   logic [7:0] area_width;
   logic [7:0] area_height;
   logic [7:0] area_row;
   logic [4:0] area_byte_column;
   logic [7:0] image_byte;
   logic [2:0] page_number;

   modport source (output valid, operation, pos_x, pos_y, pixel_on, area_width,
                   area_height, area_row, area_byte_column, image_byte,
                   page_number, input ready);
   modport sink (input valid, operation, pos_x, pos_y, pixel_on, area_width,
                 area_height, area_row, area_byte_column, image_byte,
                 page_number, output ready);
endinterface

interface fbb_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [63:0] page_word;
   logic [3:0]  valid_bytes;
   logic [3:0]  word_index;
   logic        last;

   modport source (output valid, status, page_word, valid_bytes, word_index,
                   last, input ready);
   modport sink (input valid, status, page_word, valid_bytes, word_index, last,
                 output ready);
endinterface

[rtl/fbb_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbb_lane
// One bank of the pixel store with its own read-modify-write of one bit.
// ----------------------------------------------------------------------------
module fbb_lane import fbb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  lane_cmd_type cmd,
   output logic [7:0]   rd_data
);

   logic [7:0]       mem [LANE_ROWS];
   logic [7:0]       rdata_ff;
   logic             pend_ff;
   logic [ROW_W-1:0] row_ff;
   logic [2:0]       sel_ff;
   logic             val_ff;
   logic [7:0]       wdata_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.rd_en & cmd.modify;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= mem[cmd.rd_row];
         row_ff   <= cmd.rd_row;
         sel_ff   <= cmd.bit_sel;
         val_ff   <= cmd.bit_val;
      end
   end

   always_comb begin
      logic [7:0] mask;
      mask = 8'd1 << sel_ff;
      wdata_in = val_ff ? (rdata_ff | mask) : (rdata_ff & ~mask);
   end

   // The bit update lands the cycle after its read.
   always_ff @(posedge clock) begin
      if (pend_ff) begin
         mem[row_ff] <= wdata_in;
      end else if (cmd.clr_en) begin
         mem[cmd.clr_row] <= 8'd0;
      end
   end

   assign rd_data = rdata_ff;

endmodule

[rtl/fbb_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbb_merge
// Rotates the lane read data into column order and masks unused bytes.
// ----------------------------------------------------------------------------
module fbb_merge import fbb_pkg::*; (
   input  logic [LANES-1:0][7:0] lane_data,
   input  logic [LANE_W-1:0]     rot,
   input  logic [3:0]            count,
   output logic [63:0]           word
);

   always_comb begin
      logic [LANE_W-1:0] sel;
      word = '0;
      for (int j = 0; j < LANES; j++) begin
         sel = rot + LANE_W'(j);
         if (4'(j) < count) begin
            word[8*j +: 8] = lane_data[sel];
         end
      end
   end

endmodule

[rtl/page_framebuffer_blitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_blitter
// Page-organized monochrome framebuffer: pixel draw, area byte, clear, readout.
//
//  channel  dir  handshake            contents
//  req      in   req_ch.valid/ready   operation and its operands
//  rsp      out  rsp_ch.valid/ready   status, page word, count, index, last
//  csr      in   csr_we               columns (index 0), lines (index 1)
//
// The store is eight byte-wide banks; consecutive bytes fall in distinct banks.
// Draw and area byte do a bank read, then the bit update and the response.
// Clear walks all 128 bank rows, one bank row per cycle; so does the clearing pass
// after reset, during which no request is accepted.
// Page readout reads the banks, then emits each word, and waits on any response-side stall.
// A request is accepted only in idle with the response register free.
// ----------------------------------------------------------------------------
module page_framebuffer_blitter import fbb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   fbb_req_if.sink    req_ch,
   fbb_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [7:0]       columns_ff;
   logic [6:0]       lines_ff;
   logic             init_ff;
   logic [ROW_W-1:0] clr_cnt_ff;
   logic             status_ff;
   logic [9:0]       base_ff;
   logic [7:0]       cols_ff;
   logic [3:0]       nw_m1_ff;
   logic [3:0]       k_ff;

   logic        rsp_valid_ff;
   logic        rsp_status_ff;
   logic [63:0] rsp_word_ff;
   logic [3:0]  rsp_count_ff;
   logic [3:0]  rsp_index_ff;
   logic        rsp_last_ff;

   logic [7:0]  cols_eff;
   logic [6:0]  lines_eff;
   logic        rsp_free;
   logic        accept;
   logic        draw_ok;
   logic [10:0] draw_idx;
   logic [8:0]  area_cy;
   logic        area_go;
   logic [10:0] area_idx0;
   logic [7:0]  area_x8;
   logic        page_ok;
   logic [8:0]  nw_sum;
   logic [10:0] rd_start;
   logic [8:0]  rd_left;
   logic [3:0]  rd_count;
   logic [63:0] merged;
   logic        rd_is_last;
   logic        clr_done;

   lane_cmd_type           lane_cmd [LANES];
   logic [LANES-1:0][7:0]  lane_data;

   assign cols_eff  = (columns_ff > 8'(COL_LIMIT)) ? 8'(COL_LIMIT) : columns_ff;
   assign lines_eff = (lines_ff > 7'(LINE_LIMIT)) ? 7'(LINE_LIMIT) : lines_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept    = req_ch.valid && req_ch.ready;

   // Request decode.
   assign draw_ok  = (req_ch.pos_x < cols_eff) && (req_ch.pos_y < 8'(lines_eff));
   assign draw_idx = 11'(req_ch.pos_y[5:3]) * 11'(cols_eff) + 11'(req_ch.pos_x);
   assign area_x8  = {req_ch.area_byte_column, 3'b000};
   assign area_cy  = 9'(req_ch.pos_y) + 9'(req_ch.area_row);
   assign area_go  = (req_ch.area_row < req_ch.area_height) && (area_cy < 9'(lines_eff));
   assign area_idx0 = 11'(area_cy[5:3]) * 11'(cols_eff) + 11'(req_ch.pos_x) + 11'(area_x8);
   assign page_ok  = 4'(req_ch.page_number) < lines_eff[6:3];
   assign nw_sum   = 9'(cols_eff) + 9'd7;

   // Readout word addressing.
   assign rd_start   = 11'(base_ff) + 11'({k_ff, 3'b000});
   assign rd_left    = 9'(cols_ff) - 9'({k_ff, 3'b000});
   assign rd_count   = (rd_left >= 9'd8) ? 4'd8 : rd_left[3:0];
   assign rd_is_last = (k_ff == nw_m1_ff);
   assign clr_done   = (clr_cnt_ff == ROW_W'(LANE_ROWS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op_type'(req_ch.operation))
                  OP_DRAW:  state_in = ST_WRITE;
                  OP_AREA:  state_in = ST_WRITE;
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_READ:  state_in = (page_ok && cols_eff != 8'd0) ? ST_RD_ISSUE
                                                                       : ST_WRITE;
                  default:  state_in = ST_WRITE;
               endcase
            end
         end
         ST_WRITE:    state_in = ST_IDLE;
         ST_CLEAR:    if (clr_done) state_in = ST_IDLE;
         ST_RD_ISSUE: state_in = ST_RD_EMIT;
         ST_RD_EMIT: begin
            if (rsp_free) begin
               state_in = rd_is_last ? ST_IDLE : ST_RD_ISSUE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      logic [LANE_W-1:0] i;
      logic [7:0]        ix;
      logic [8:0]        dx;
      logic [10:0]       idx;
      for (int l = 0; l < LANES; l++) begin
         lane_cmd[l] = '0;
         lane_cmd[l].clr_row = clr_cnt_ff;
         i   = '0;
         ix  = '0;
         dx  = '0;
         idx = '0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && op_type'(req_ch.operation) == OP_DRAW) begin
                  lane_cmd[l].rd_en   = draw_ok && (draw_idx[2:0] == LANE_W'(l));
                  lane_cmd[l].rd_row  = draw_idx[9:3];
                  lane_cmd[l].modify  = 1'b1;
                  lane_cmd[l].bit_sel = req_ch.pos_y[2:0];
                  lane_cmd[l].bit_val = req_ch.pixel_on;
               end else if (accept && op_type'(req_ch.operation) == OP_AREA) begin
                  // Pixel i of the byte lands in the lane its store index maps to.
                  i   = LANE_W'(l) - area_idx0[2:0];
                  ix  = area_x8 + 8'(i);
                  dx  = 9'(req_ch.pos_x) + 9'(ix);
                  idx = area_idx0 + 11'(i);
                  lane_cmd[l].rd_en   = area_go && (ix < req_ch.area_width)
                                        && (dx < 9'(cols_eff));
                  lane_cmd[l].rd_row  = idx[9:3];
                  lane_cmd[l].modify  = 1'b1;
                  lane_cmd[l].bit_sel = area_cy[2:0];
                  lane_cmd[l].bit_val = req_ch.image_byte[3'd7 - i];
               end
            end
            ST_CLEAR: begin
               lane_cmd[l].clr_en = 1'b1;
            end
            ST_RD_ISSUE: begin
               i   = LANE_W'(l) - rd_start[2:0];
               idx = rd_start + 11'(i);
               lane_cmd[l].rd_en  = 1'b1;
               lane_cmd[l].rd_row = idx[9:3];
            end
            default: begin
               lane_cmd[l].rd_en = 1'b0;
            end
         endcase
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      fbb_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .cmd     (lane_cmd[l]),
         .rd_data (lane_data[l])
      );
   end

   fbb_merge u_merge (
      .lane_data (lane_data),
      .rot       (rd_start[2:0]),
      .count     (rd_count),
      .word      (merged)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         init_ff      <= 1'b1;
         clr_cnt_ff   <= '0;
         columns_ff   <= 8'd128;
         lines_ff     <= 7'd64;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_COLUMNS: columns_ff <= csr_wdata;
               CSR_LINES:   lines_ff   <= csr_wdata[6:0];
               default:     columns_ff <= columns_ff;
            endcase
         end
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_done) begin
               init_ff <= 1'b0;
            end
         end
         if (accept) begin
            k_ff <= '0;
         end else if (state_ff == ST_RD_EMIT && rsp_free && !rd_is_last) begin
            k_ff <= k_ff + 1'b1;
         end
         if (state_ff == ST_WRITE || (state_ff == ST_CLEAR && clr_done && !init_ff)
             || (state_ff == ST_RD_EMIT && rsp_free)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         case (op_type'(req_ch.operation))
            OP_DRAW: status_ff <= !draw_ok;
            OP_READ: status_ff <= !page_ok;
            default: status_ff <= 1'b0;
         endcase
         base_ff  <= 10'(req_ch.page_number) * 10'(cols_eff);
         cols_ff  <= cols_eff;
         nw_m1_ff <= 4'(nw_sum[8:3] - 6'd1);
      end
      if (state_ff == ST_WRITE || state_ff == ST_CLEAR) begin
         rsp_status_ff <= (state_ff == ST_WRITE) ? status_ff : 1'b0;
         rsp_word_ff   <= '0;
         rsp_count_ff  <= '0;
         rsp_index_ff  <= '0;
         rsp_last_ff   <= 1'b1;
      end else if (state_ff == ST_RD_EMIT && rsp_free) begin
         rsp_status_ff <= 1'b0;
         rsp_word_ff   <= merged;
         rsp_count_ff  <= rd_count;
         rsp_index_ff  <= k_ff;
         rsp_last_ff   <= rd_is_last;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.page_word   = rsp_word_ff;
   assign rsp_ch.valid_bytes = rsp_count_ff;
   assign rsp_ch.word_index  = rsp_index_ff;
   assign rsp_ch.last        = rsp_last_ff;

endmodule

[tb/page_framebuffer_blitter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_blitter_test
// Drives draw, area byte, clear and page read requests into the blitter under
// several register settings and flow-control phases. A local framebuffer
// model predicts every response, which is checked field by field in order.
// ----------------------------------------------------------------------------
module page_framebuffer_blitter_test;
   import fbb_pkg::*;

   typedef struct packed {
      op_type     operation;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic       pixel_on;
      logic [7:0] area_width;
      logic [7:0] area_height;
      logic [7:0] area_row;
      logic [4:0] area_byte_column;
      logic [7:0] image_byte;
      logic [2:0] page_number;
   } blit_req_type;

   typedef struct packed {
      logic        status;
      logic [63:0] page_word;
      logic [3:0]  valid_bytes;
      logic [3:0]  word_index;
      logic        last;
   } blit_rsp_type;

   localparam int CYCLE_LIMIT = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic       csr_index = CSR_COLUMNS;
   logic [7:0] csr_wdata = 8'd0;

   fbb_req_if req_ch ();
   fbb_rsp_if rsp_ch ();

   page_framebuffer_blitter dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Model state.
   logic [7:0] fb_bytes [STORE_BYTES];
   int unsigned fb_columns;
   int unsigned fb_lines;

   blit_req_type pending_reqs [$];
   blit_rsp_type expected_rsps [$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;
   int cycle_count = 0;

   function automatic int unsigned eff_cols();
      return (fb_columns > COL_LIMIT) ? COL_LIMIT : fb_columns;
   endfunction

   function automatic int unsigned eff_lines();
      return (fb_lines > LINE_LIMIT) ? LINE_LIMIT : fb_lines;
   endfunction

   function automatic void plot(int unsigned x, int unsigned y, logic on);
      int unsigned idx;
      if (x >= eff_cols() || y >= eff_lines()) return;
      idx = ((y >> 3) * eff_cols() + x) % STORE_BYTES;
      fb_bytes[idx][y & 7] = on;
   endfunction

   function automatic void predict_blit(blit_req_type r);
      blit_rsp_type rsp;
      int unsigned cols, nwords, ix, c, cy;
      rsp = '0;
      rsp.last = 1'b1;
      case (r.operation)
         OP_DRAW: begin
            rsp.status = (r.pos_x >= eff_cols() || r.pos_y >= eff_lines());
            plot(r.pos_x, r.pos_y, r.pixel_on);
            expected_rsps.push_back(rsp);
         end
         OP_AREA: begin
            if (r.area_row < r.area_height) begin
               cy = int'(r.pos_y) + int'(r.area_row);
               for (int i = 0; i < 8; i++) begin
                  ix = r.area_byte_column * 8 + i;
                  if (ix >= r.area_width) break;
                  plot(int'(r.pos_x) + ix, cy, r.image_byte[7 - i]);
               end
            end
            expected_rsps.push_back(rsp);
         end
         OP_CLEAR: begin
            foreach (fb_bytes[i]) fb_bytes[i] = 8'd0;
            expected_rsps.push_back(rsp);
         end
         default: begin
            cols = eff_cols();
            if (r.page_number >= (eff_lines() >> 3)) begin
               rsp.status = 1'b1;
               expected_rsps.push_back(rsp);
            end else if (cols == 0) begin
               expected_rsps.push_back(rsp);
            end else begin
               nwords = (cols + 7) / 8;
               for (int k = 0; k < nwords; k++) begin
                  rsp = '0;
                  for (int j = 0; j < 8; j++) begin
                     c = k * 8 + j;
                     if (c >= cols) break;
                     rsp.page_word[8*j +: 8] =
                        fb_bytes[(r.page_number * cols + c) % STORE_BYTES];
                     rsp.valid_bytes++;
                  end
                  rsp.word_index = 4'(k);
                  rsp.last = (k + 1 == nwords);
                  expected_rsps.push_back(rsp);
               end
            end
         end
      endcase
   endfunction

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            blit_req_type r;
            r = pending_reqs.pop_front();
            predict_blit(r);
            req_ch.valid <= 1'b1;
            req_ch.operation <= r.operation;
            req_ch.pos_x <= r.pos_x;
            req_ch.pos_y <= r.pos_y;
            req_ch.pixel_on <= r.pixel_on;
            req_ch.area_width <= r.area_width;
            req_ch.area_height <= r.area_height;
            req_ch.area_row <= r.area_row;
            req_ch.area_byte_column <= r.area_byte_column;
            req_ch.image_byte <= r.image_byte;
            req_ch.page_number <= r.page_number;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver readiness, with an optional long hold-off.
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response");
            errors++;
         end else begin
            blit_rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_ch.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_ch.status);
               errors++;
            end
            if (rsp_ch.page_word !== e.page_word) begin
               $error("page_word expected %h actual %h", e.page_word, rsp_ch.page_word);
               errors++;
            end
            if (rsp_ch.valid_bytes !== e.valid_bytes) begin
               $error("valid_bytes expected %0d actual %0d", e.valid_bytes,
                      rsp_ch.valid_bytes);
               errors++;
            end
            if (rsp_ch.word_index !== e.word_index) begin
               $error("word_index expected %0d actual %0d", e.word_index,
                      rsp_ch.word_index);
               errors++;
            end
            if (rsp_ch.last !== e.last) begin
               $error("last expected %0d actual %0d", e.last, rsp_ch.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("page_framebuffer_blitter test failed");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.operation = OP_DRAW;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pixel_on = 1'b0;
      req_ch.area_width = '0;
      req_ch.area_height = '0;
      req_ch.area_row = '0;
      req_ch.area_byte_column = '0;
      req_ch.image_byte = '0;
      req_ch.page_number = '0;
      rsp_ch.ready = 1'b0;
      foreach (fb_bytes[i]) fb_bytes[i] = 8'd0;
      fb_columns = 128;
      fb_lines = 64;
   end

   function automatic blit_req_type make_req(op_type op, int x, int y, int on, int aw,
                                             int ah, int row, int bcol, int img,
                                             int page);
      blit_req_type r;
      r.operation = op;
      r.pos_x = 8'(x);
      r.pos_y = 8'(y);
      r.pixel_on = 1'(on);
      r.area_width = 8'(aw);
      r.area_height = 8'(ah);
      r.area_row = 8'(row);
      r.area_byte_column = 5'(bcol);
      r.image_byte = 8'(img);
      r.page_number = 3'(page);
      return r;
   endfunction

   function automatic blit_req_type random_req();
      blit_req_type r;
      int pick;
      r = make_req(OP_DRAW, $urandom_range(255), $urandom_range(255), $urandom_range(1),
                   $urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(254),
                   $urandom_range(31), $urandom_range(255), $urandom_range(7));
      pick = $urandom_range(99);
      if (pick < 40) begin
         r.operation = OP_DRAW;
         if ($urandom_range(3) != 0) begin
            r.pos_x = 8'($urandom_range(eff_cols() + 1));
            r.pos_y = 8'($urandom_range(eff_lines()));
         end
      end else if (pick < 75) begin
         r.operation = OP_AREA;
         if ($urandom_range(3) != 0) begin
            r.pos_x = 8'($urandom_range(eff_cols()));
            r.pos_y = 8'($urandom_range(eff_lines()));
            r.area_width = 8'($urandom_range(1, 40));
            r.area_height = 8'($urandom_range(1, 16));
            r.area_row = 8'($urandom_range(17));
            r.area_byte_column = 5'($urandom_range(5));
         end
      end else if (pick < 80) begin
         r.operation = OP_CLEAR;
      end else begin
         r.operation = OP_READ;
      end
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 8'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_COLUMNS) fb_columns = value & 8'hff;
      else fb_lines = value & 8'h7f;
   endtask

   task automatic random_phase(int count, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (count) pending_reqs.push_back(random_req());
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (300) @(posedge clock);

      // Directed: corners, clipping, out-of-range pages, register extremes.
      pending_reqs.push_back(make_req(OP_DRAW, 0, 0, 1, 1, 1, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_DRAW, 127, 63, 1, 1, 1, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_DRAW, 128, 0, 1, 1, 1, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_DRAW, 0, 64, 1, 1, 1, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_DRAW, 255, 255, 0, 255, 255, 254, 31, 255, 7));
      pending_reqs.push_back(make_req(OP_AREA, 120, 60, 0, 20, 8, 3, 1, 8'hA5, 0));
      pending_reqs.push_back(make_req(OP_AREA, 0, 0, 0, 5, 4, 0, 0, 8'hFF, 0));
      pending_reqs.push_back(make_req(OP_AREA, 0, 0, 0, 255, 4, 4, 0, 8'hFF, 0));
      pending_reqs.push_back(make_req(OP_AREA, 255, 255, 1, 255, 255, 254, 31, 8'hFF, 7));
      pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 1, 1, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 1, 1, 0, 0, 0, 7));
      pending_reqs.push_back(make_req(OP_CLEAR, 0, 0, 0, 1, 1, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 1, 1, 0, 0, 0, 7));
      wait_drained();

      write_csr(CSR_COLUMNS, 255);
      write_csr(CSR_LINES, 8'hFF);
      pending_reqs.push_back(make_req(OP_DRAW, 127, 63, 1, 1, 1, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 1, 1, 0, 0, 0, 7));
      wait_drained();
      write_csr(CSR_COLUMNS, 0);
      write_csr(CSR_LINES, 8);
      pending_reqs.push_back(make_req(OP_DRAW, 0, 0, 1, 1, 1, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 1, 1, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 1, 1, 0, 0, 0, 1));
      wait_drained();
      write_csr(CSR_COLUMNS, 13);
      write_csr(CSR_LINES, 13);
      pending_reqs.push_back(make_req(OP_DRAW, 12, 12, 1, 1, 1, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 1, 1, 0, 0, 0, 1));
      wait_drained();

      write_csr(CSR_COLUMNS, 128);
      write_csr(CSR_LINES, 64);
      random_phase(40, 0, 0);
      write_csr(CSR_COLUMNS, 1);
      write_csr(CSR_LINES, 17);
      random_phase(25, 55, 0);
      write_csr(CSR_COLUMNS, $urandom_range(2, 127));
      write_csr(CSR_LINES, $urandom_range(8, 64));
      random_phase(25, 0, 55);
      write_csr(CSR_COLUMNS, 128);
      write_csr(CSR_LINES, 64);
      random_phase(30, 29, 29);

      // Long receiver hold-off while requests keep coming.
      hold_off = 300;
      random_phase(30, 0, 0);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      if (errors == 0) begin
         $display("page_framebuffer_blitter test passed");
      end else begin
         $display("page_framebuffer_blitter test failed");
      end
      $finish;
   end

endmodule
